FILE: design/necir_pkg.sv
// shared constants for the nec infrared frame decoder
package necir_pkg;

   localparam int unsigned TIME_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 6;
   localparam int unsigned ADDR_W  = 5;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned INDEX_W = 3;

   typedef logic [INDEX_W-1:0] reg_index_type;

   localparam reg_index_type REG_LEADER_MIN = 3'd0;
   localparam reg_index_type REG_LEADER_MAX = 3'd1;
   localparam reg_index_type REG_ZERO_MIN   = 3'd2;
   localparam reg_index_type REG_ZERO_MAX   = 3'd3;
   localparam reg_index_type REG_ONE_MIN    = 3'd4;
   localparam reg_index_type REG_ONE_MAX    = 3'd5;
   localparam reg_index_type REG_KEY_OFFSET = 3'd6;

   localparam logic [TIME_W-1:0] LEADER_MIN_RST = 16'd1300;
   localparam logic [TIME_W-1:0] LEADER_MAX_RST = 16'd1400;
   localparam logic [TIME_W-1:0] ZERO_MIN_RST   = 16'd92;
   localparam logic [TIME_W-1:0] ZERO_MAX_RST   = 16'd132;
   localparam logic [TIME_W-1:0] ONE_MIN_RST    = 16'd205;
   localparam logic [TIME_W-1:0] ONE_MAX_RST    = 16'd245;
   localparam logic [BYTE_W-1:0] KEY_OFFSET_RST = 8'd0;

   localparam logic [COUNT_W-1:0] CNT_ADDR_LO = 6'd8;
   localparam logic [COUNT_W-1:0] CNT_ADDR_HI = 6'd16;
   localparam logic [COUNT_W-1:0] CNT_CMD     = 6'd24;
   localparam logic [COUNT_W-1:0] CNT_FRAME   = 6'd32;
   localparam logic [COUNT_W-1:0] CNT_LAST    = 6'd31;

   localparam logic [BYTE_W:0] CHECK_SUM = 9'd255;

endpackage

FILE: design/nec_ir_frame_decoder_core.sv
// nec infrared frame decoder top level: capture register, frame decode, result register
//
//   channel   ports                      direction  content
//   req       req_valid/ready, 16 bit    in         capture timestamp word
//   rsp       rsp_valid/ready, 4x8 bit   out        key, command, address low/high word
//   csr       apb, 5 bit addr, 32 bit    in/out     seven window and offset registers
//
// one word per cycle unless the result stalls; a word waits in the capture register,
// is decoded against the frame state and, on a good 32nd bit, lands in the result
// register as it leaves the capture register. a stalled result holds the capture
// register once it is full; the request side keeps taking words while the result is free.
// synchronous active-high reset clears frame state, last timestamp, configuration registers and valid flags.
module nec_ir_frame_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_capture_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_key_code,
   output logic [7:0]  rsp_command_byte,
   output logic [7:0]  rsp_address_low,
   output logic [7:0]  rsp_address_high,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [15:0] leader_min_ff, leader_max_ff, zero_min_ff, zero_max_ff;
   logic [15:0] one_min_ff, one_max_ff;
   logic [7:0]  key_offset_ff;
   logic        csr_write;
   necir_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         leader_min_ff <= necir_pkg::LEADER_MIN_RST;
         leader_max_ff <= necir_pkg::LEADER_MAX_RST;
         zero_min_ff   <= necir_pkg::ZERO_MIN_RST;
         zero_max_ff   <= necir_pkg::ZERO_MAX_RST;
         one_min_ff    <= necir_pkg::ONE_MIN_RST;
         one_max_ff    <= necir_pkg::ONE_MAX_RST;
         key_offset_ff <= necir_pkg::KEY_OFFSET_RST;
      end else if (csr_write) begin
         case (csr_index)
            necir_pkg::REG_LEADER_MIN: leader_min_ff <= csr_pwdata[15:0];
            necir_pkg::REG_LEADER_MAX: leader_max_ff <= csr_pwdata[15:0];
            necir_pkg::REG_ZERO_MIN:   zero_min_ff   <= csr_pwdata[15:0];
            necir_pkg::REG_ZERO_MAX:   zero_max_ff   <= csr_pwdata[15:0];
            necir_pkg::REG_ONE_MIN:    one_min_ff    <= csr_pwdata[15:0];
            necir_pkg::REG_ONE_MAX:    one_max_ff    <= csr_pwdata[15:0];
            necir_pkg::REG_KEY_OFFSET: key_offset_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         necir_pkg::REG_LEADER_MIN: csr_prdata = {16'd0, leader_min_ff};
         necir_pkg::REG_LEADER_MAX: csr_prdata = {16'd0, leader_max_ff};
         necir_pkg::REG_ZERO_MIN:   csr_prdata = {16'd0, zero_min_ff};
         necir_pkg::REG_ZERO_MAX:   csr_prdata = {16'd0, zero_max_ff};
         necir_pkg::REG_ONE_MIN:    csr_prdata = {16'd0, one_min_ff};
         necir_pkg::REG_ONE_MAX:    csr_prdata = {16'd0, one_max_ff};
         necir_pkg::REG_KEY_OFFSET: csr_prdata = {24'd0, key_offset_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // capture register
   logic        cap_valid_ff, cap_valid_in;
   logic [15:0] cap_time_ff;
   logic        advance;

   assign advance   = cap_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !cap_valid_ff || advance;

   always_comb begin
      cap_valid_in = cap_valid_ff;
      if (req_valid && req_ready) begin
         cap_valid_in = 1'b1;
      end else if (advance) begin
         cap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= cap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cap_time_ff <= req_capture_time;
      end
   end

   // frame state
   logic        frame_ff, frame_in;
   logic [15:0] last_ff;
   logic [7:0]  shift_ff, shift_in;
   logic [5:0]  bit_cnt_ff, bit_cnt_in;
   logic [7:0]  addr_lo_ff, addr_lo_in, addr_hi_ff, addr_hi_in, cmd_ff, cmd_in;
   logic [15:0] width;
   logic        skip, is_leader, is_zero, is_one, hit;
   logic [7:0]  shifted;
   logic [5:0]  cnt_next;
   logic [8:0]  check_sum;

   assign width     = cap_time_ff - last_ff - {15'd0, (cap_time_ff < last_ff)};
   assign skip      = !frame_ff && (last_ff == 16'd0);
   assign is_leader = (width > leader_min_ff) && (width < leader_max_ff);
   assign is_zero   = (width > zero_min_ff) && (width < zero_max_ff);
   assign is_one    = (width > one_min_ff) && (width < one_max_ff);
   assign shifted   = {(!is_zero && is_one), shift_ff[7:1]};
   assign cnt_next  = bit_cnt_ff + 6'd1;
   assign check_sum = {1'b0, cmd_ff} + {1'b0, shifted};

   always_comb begin
      frame_in   = frame_ff;
      shift_in   = shift_ff;
      bit_cnt_in = bit_cnt_ff;
      addr_lo_in = addr_lo_ff;
      addr_hi_in = addr_hi_ff;
      cmd_in     = cmd_ff;
      hit        = 1'b0;
      if (skip) begin
         frame_in = 1'b0;
      end else if (!frame_ff) begin
         if (is_leader) begin
            frame_in   = 1'b1;
            shift_in   = 8'd0;
            bit_cnt_in = 6'd0;
         end
      end else if (is_zero || is_one) begin
         shift_in   = shifted;
         bit_cnt_in = cnt_next;
         case (cnt_next)
            necir_pkg::CNT_ADDR_LO: begin
               addr_lo_in = shifted;
               shift_in   = 8'd0;
            end
            necir_pkg::CNT_ADDR_HI: begin
               addr_hi_in = shifted;
               shift_in   = 8'd0;
            end
            necir_pkg::CNT_CMD: begin
               cmd_in   = shifted;
               shift_in = 8'd0;
            end
            necir_pkg::CNT_FRAME: begin
               frame_in = 1'b0;
               hit      = (check_sum == necir_pkg::CHECK_SUM);
            end
            default: ;
         endcase
      end else if (is_leader) begin
         frame_in   = 1'b1;
         shift_in   = 8'd0;
         bit_cnt_in = 6'd0;
      end else begin
         frame_in = 1'b0;
         shift_in = shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff   <= 1'b0;
         last_ff    <= 16'd0;
         shift_ff   <= 8'd0;
         bit_cnt_ff <= 6'd0;
      end else if (advance) begin
         frame_ff   <= frame_in;
         last_ff    <= cap_time_ff;
         shift_ff   <= shift_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         addr_lo_ff <= addr_lo_in;
         addr_hi_ff <= addr_hi_in;
         cmd_ff     <= cmd_in;
      end
   end

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] key_ff, cmd_out_ff, addr_lo_out_ff, addr_hi_out_ff;
   logic       load;

   assign load = advance && hit;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff         <= cmd_ff + key_offset_ff;
         cmd_out_ff     <= cmd_ff;
         addr_lo_out_ff <= addr_lo_ff;
         addr_hi_out_ff <= addr_hi_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_code     = key_ff;
   assign rsp_command_byte = cmd_out_ff;
   assign rsp_address_low  = addr_lo_out_ff;
   assign rsp_address_high = addr_hi_out_ff;

   // checks
   a_hit_on_last_bit: assert property (@(posedge clock) disable iff (reset)
      load |-> (frame_ff && bit_cnt_ff == necir_pkg::CNT_LAST))
      else $error("result produced outside the final bit of a frame");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= necir_pkg::CNT_FRAME)
      else $error("bit count beyond frame length");

   a_cap_hold: assert property (@(posedge clock) disable iff (reset)
      (cap_valid_ff && !advance) |=> (cap_valid_ff && $stable(cap_time_ff)))
      else $error("stalled capture word lost or changed");

   a_idle_after_frame: assert property (@(posedge clock) disable iff (reset)
      load |=> !frame_ff)
      else $error("frame still open after a result");

endmodule
